@@ sv/vap_pkg.sv @@
`default_nettype none
package vap_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned VAR_W    = 8;
  localparam int unsigned ACT_W    = 64;
  localparam int unsigned AV_W     = 9;
  localparam int unsigned RECIP_W  = 18;
  // index compare width: covers cell indices up to 8191 and active_vars
  localparam int unsigned CMP_W    = 13;
  localparam int unsigned CHUNK_W  = 16;
  localparam int unsigned CHUNKS   = ACT_W / CHUNK_W;
  localparam int unsigned STEP_W   = 2;
  localparam int unsigned ACC_W    = ACT_W + RECIP_W;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned RESCALE_SHIFT = 40;
  localparam logic [ACT_W-1:0] RESCALE_LIMIT = 64'h1000_0000_0000_0000;
  localparam logic [ACT_W-1:0] INC_RESET     = 64'd65536;
  localparam logic [AV_W-1:0]  AV_RESET      = 9'd256;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 18'd68985;

  localparam logic [FUNC_W-1:0] FUNC_BUMP  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DECAY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PICK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd3;

  localparam logic REG_ACTIVE_VARS = 1'b0;
  localparam logic REG_DECAY_RECIP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUMP_CHK,
    ST_DECAY,
    ST_PICK,
    ST_PUSH
  } vap_state_e;

  // broadcast to every cell
  typedef struct packed {
    logic             bump;
    logic             mark;
    logic             shift;
    logic [VAR_W-1:0] var_index;
    logic             flag;
    logic [ACT_W-1:0] inc;
    logic [AV_W-1:0]  active_vars;
  } vap_cmd_t;

  // running best of a pick, handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             have;
    logic [VAR_W-1:0] idx;
    logic [ACT_W-1:0] act;
  } vap_scan_t;

endpackage
`default_nettype wire

@@ sv/vap_if.sv @@
`default_nettype none
interface vap_req_if;
  logic                        valid;
  logic                        ready;
  logic [vap_pkg::FUNC_W-1:0]  func;
  logic [vap_pkg::VAR_W-1:0]   var_index;
  logic                        assigned_flag;

  modport source (output valid, func, var_index, assigned_flag, input ready);
  modport sink   (input valid, func, var_index, assigned_flag, output ready);
endinterface

interface vap_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [vap_pkg::VAR_W-1:0]  picked_var;
  logic                       found;

  modport source (output valid, picked_var, found, input ready);
  modport sink   (input valid, picked_var, found, output ready);
endinterface
`default_nettype wire

@@ sv/vap_cell.sv @@
`default_nettype none
module vap_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vap_pkg::vap_cmd_t  cmd_i,
  input  wire vap_pkg::vap_scan_t scan_i,
  output vap_pkg::vap_scan_t      scan_o,
  output logic                    over_o
);
  import vap_pkg::*;

  localparam logic [CMP_W-1:0] OwnIdx = CMP_W'(CELL_IDX);

  logic [ACT_W-1:0] act_q, act_d;
  logic             assigned_q, assigned_d;
  logic             over_q, over_d;
  vap_scan_t        scan_q, scan_d;
  logic             hit, live;
  logic [ACT_W:0]   sum_wide;
  logic [ACT_W-1:0] sum;

  assign hit      = (OwnIdx == CMP_W'(cmd_i.var_index));
  assign live     = (OwnIdx < CMP_W'(cmd_i.active_vars));
  assign sum_wide = {1'b0, act_q} + {1'b0, cmd_i.inc};
  assign sum      = sum_wide[ACT_W] ? {ACT_W{1'b1}} : sum_wide[ACT_W-1:0];

  always_comb begin
    act_d  = act_q;
    over_d = 1'b0;
    if (cmd_i.bump && hit && live) begin
      act_d  = sum;
      over_d = (sum > RESCALE_LIMIT);
    end else if (cmd_i.shift && live) begin
      act_d = act_q >> RESCALE_SHIFT;
    end
  end

  assign assigned_d = (cmd_i.mark && hit) ? cmd_i.flag : assigned_q;

  // take over the running best when none is held yet or on strictly greater activity
  always_comb begin
    scan_d = scan_i;
    if (scan_i.valid && live && !assigned_q &&
        (!scan_i.have || (act_q > scan_i.act))) begin
      scan_d.have = 1'b1;
      scan_d.idx  = OwnIdx[VAR_W-1:0];
      scan_d.act  = act_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= '0;
      assigned_q <= 1'b0;
      over_q     <= 1'b0;
      scan_q     <= '0;
    end else begin
      act_q      <= act_d;
      assigned_q <= assigned_d;
      over_q     <= over_d;
      scan_q     <= scan_d;
    end
  end

  assign scan_o = scan_q;
  assign over_o = over_q;

endmodule
`default_nettype wire

@@ sv/vap_decay_unit.sv @@
`default_nettype none
module vap_decay_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [vap_pkg::ACT_W-1:0]     inc_i,
  input  wire logic [vap_pkg::RECIP_W-1:0]   recip_i,
  output logic                               done_o,
  output logic [vap_pkg::ACT_W-1:0]          inc_o
);
  import vap_pkg::*;

  localparam int unsigned PROD_W = CHUNK_W + RECIP_W;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [CHUNK_W-1:0]  chunk;
  logic [PROD_W-1:0]   prod;
  logic [ACT_W-1:0]    res_raw;
  logic                res_ovf;

  // Horner over 16-bit chunks, top chunk first
  assign chunk = inc_i[CHUNK_W*cnt_q +: CHUNK_W];
  assign prod  = PROD_W'(chunk) * PROD_W'(recip_i);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(CHUNKS - 1);
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = {acc_q[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(prod);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // drop the Q16 fraction, saturate, hold at least 1
  assign res_raw = acc_q[CHUNK_W+ACT_W-1:CHUNK_W];
  assign res_ovf = |acc_q[ACC_W-1:CHUNK_W+ACT_W];

  always_comb begin
    if (res_ovf) begin
      inc_o = {ACT_W{1'b1}};
    end else if (res_raw == '0) begin
      inc_o = ACT_W'(1);
    end else begin
      inc_o = res_raw;
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

@@ sv/vsids_activity_picker_unit.sv @@
`default_nettype none
// Channel   Dir  Payload                             Handshake
// req_i     in   func, var_index, assigned_flag      valid/ready
// rsp_o     out  picked_var, found                   valid/ready
// apb       in   paddr, pwdata -> prdata             psel/penable/pwrite, pready=1
//
// One request at a time. Set-mark is done on acceptance; bump adds, then
// does the rescale check and shift; decay runs four 16x18 multiply steps
// of the decay unit. A pick walks a token down the row of NUM_VARS cells,
// one cell per cycle, then pushes its result to the output slot.
// Reset clears every activity and mark at once; no clearing pass.
// A stalled result holds in the output register; the next request is
// taken meanwhile, and only a pick finishing behind it waits for the slot.
module vsids_activity_picker_unit #(
  parameter int unsigned NUM_VARS = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  vap_req_if.sink                             req_i,
  vap_rsp_if.source                           rsp_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [vap_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [vap_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vap_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import vap_pkg::*;

  vap_state_e          state_q, state_d;
  logic [ACT_W-1:0]    inc_q, inc_d;
  logic [AV_W-1:0]     active_vars_q;
  logic [RECIP_W-1:0]  decay_recip_q;
  logic [VAR_W-1:0]    hold_var_q;
  logic                hold_found_q;
  logic                rsp_valid_q, rsp_valid_d;
  logic [VAR_W-1:0]    rsp_var_q;
  logic                rsp_found_q;

  logic                accept;
  logic                cfg_wr;
  logic                rsp_load;
  logic                any_over;
  logic                dec_start;
  logic                dec_done;
  logic [ACT_W-1:0]    dec_inc;
  logic [ACT_W-1:0]    inc_shifted;
  vap_cmd_t            cmd;
  vap_scan_t           scan_head;
  vap_scan_t           scan [NUM_VARS+1];
  logic [NUM_VARS-1:0] over_vec;

  assign accept   = req_i.valid && req_i.ready;
  assign any_over = |over_vec;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_vars_q <= AV_RESET;
      decay_recip_q <= RECIP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ACTIVE_VARS) begin
        active_vars_q <= pwdata[AV_W-1:0];
      end else begin
        decay_recip_q <= pwdata[RECIP_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_DECAY_RECIP) ? APB_DATA_W'(decay_recip_q)
                                                : APB_DATA_W'(active_vars_q);

  // -------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.func)
            FUNC_BUMP:  state_d = ST_BUMP_CHK;
            FUNC_DECAY: state_d = ST_DECAY;
            FUNC_PICK:  state_d = ST_PICK;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_BUMP_CHK: state_d = ST_IDLE;
      ST_DECAY:    if (dec_done) state_d = ST_IDLE;
      ST_PICK:     if (scan[NUM_VARS].valid) state_d = ST_PUSH;
      ST_PUSH:     if (rsp_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ----------------------------------------------------------- outputs
  always_comb begin
    req_i.ready     = (state_q == ST_IDLE);
    dec_start       = 1'b0;
    cmd.bump        = 1'b0;
    cmd.mark        = 1'b0;
    cmd.shift       = 1'b0;
    cmd.var_index   = req_i.var_index;
    cmd.flag        = req_i.assigned_flag;
    cmd.inc         = inc_q;
    cmd.active_vars = active_vars_q;
    scan_head       = '0;
    rsp_load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd.bump        = accept && (req_i.func == FUNC_BUMP);
        cmd.mark        = accept && (req_i.func == FUNC_MARK);
        dec_start       = accept && (req_i.func == FUNC_DECAY);
        // inject an empty running best at the head of the row
        scan_head.valid = accept && (req_i.func == FUNC_PICK);
      end
      ST_BUMP_CHK: cmd.shift = any_over;
      ST_PUSH:     rsp_load  = !rsp_valid_q || rsp_o.ready;
      default: begin
      end
    endcase
  end

  assign scan[0] = scan_head;

  // -------------------------------------------------- increment update
  assign inc_shifted = ((inc_q >> RESCALE_SHIFT) == '0) ? ACT_W'(1)
                                                        : (inc_q >> RESCALE_SHIFT);

  always_comb begin
    inc_d = inc_q;
    if (cmd.shift) begin
      inc_d = inc_shifted;
    end else if ((state_q == ST_DECAY) && dec_done) begin
      inc_d = dec_inc;
    end
  end

  // ------------------------------------------------------ result slot
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inc_q       <= INC_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inc_q       <= inc_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload: capture the token at the tail, then load the output slot
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PICK) && scan[NUM_VARS].valid) begin
      hold_var_q   <= scan[NUM_VARS].have ? scan[NUM_VARS].idx : '0;
      hold_found_q <= scan[NUM_VARS].have;
    end
    if (rsp_load) begin
      rsp_var_q   <= hold_var_q;
      rsp_found_q <= hold_found_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.picked_var = rsp_var_q;
  assign rsp_o.found      = rsp_found_q;

  // ------------------------------------------------------- cell row
  for (genvar g = 0; g < NUM_VARS; g++) begin : g_cell
    vap_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .scan_i (scan[g]),
      .scan_o (scan[g+1]),
      .over_o (over_vec[g])
    );
  end

  vap_decay_unit u_decay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dec_start),
    .inc_i   (inc_q),
    .recip_i (decay_recip_q),
    .done_o  (dec_done),
    .inc_o   (dec_inc)
  );

endmodule
`default_nettype wire

@@ sv/vap_checker.sv @@
`default_nettype none
module vap_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         req_valid_i,
  input wire logic                         req_ready_i,
  input wire logic [vap_pkg::FUNC_W-1:0]   req_func_i,
  input wire logic                         rsp_valid_i,
  input wire logic                         rsp_ready_i,
  input wire logic [vap_pkg::VAR_W-1:0]    rsp_picked_var_i,
  input wire logic                         rsp_found_i
);
  import vap_pkg::*;

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> rsp_picked_var_i == '0)
    else $error("picked_var not zero without a free variable");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_func_i != FUNC_PICK) |=> !$rose(rsp_valid_i))
    else $error("result raised by a request that gives none");

  a_pick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_func_i == FUNC_PICK) |=> !req_ready_i)
    else $error("request taken while a pick walks the row");

endmodule

bind vsids_activity_picker_unit vap_checker u_vap_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_func_i       (req_i.func),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_picked_var_i (rsp_o.picked_var),
  .rsp_found_i      (rsp_o.found)
);
`default_nettype wire

@@ dv/vap_pick_predictor.sv @@
`default_nettype none
module vap_pick_predictor #(
  parameter int unsigned NUM_VARS = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  vap_req_if                                  req_i,
  vap_rsp_if                                  rsp_i,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic                           pready,
  input  wire logic [vap_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [vap_pkg::APB_DATA_W-1:0] pwdata,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  import vap_pkg::*;

  typedef struct packed {
    logic [VAR_W-1:0] picked_var;
    logic             found;
  } pick_result_t;

  pick_result_t     expected_picks[$];
  logic [ACT_W-1:0] activity [NUM_VARS];
  logic             marks    [NUM_VARS];
  logic [ACT_W-1:0] bump_inc;
  logic [AV_W-1:0]  active_vars;
  logic [RECIP_W-1:0] decay_recip;
  int unsigned      mismatches;

  function automatic int unsigned live_count();
    return (active_vars > NUM_VARS) ? NUM_VARS : int'(active_vars);
  endfunction

  function automatic void apply_bump(input logic [VAR_W-1:0] v);
    logic [ACT_W:0] sum;
    int unsigned    n;
    int unsigned    i;
    n = live_count();
    if (v >= n) return;
    sum = {1'b0, activity[v]} + {1'b0, bump_inc};
    activity[v] = sum[ACT_W] ? '1 : sum[ACT_W-1:0];
    if (activity[v] > RESCALE_LIMIT) begin
      for (i = 0; i < n; i++) activity[i] = activity[i] >> RESCALE_SHIFT;
      bump_inc = bump_inc >> RESCALE_SHIFT;
      if (bump_inc == '0) bump_inc = ACT_W'(1);
    end
  endfunction

  // floor(inc * recip / 2^16), saturated to 64 bits, never below 1
  function automatic void apply_decay();
    logic [ACC_W-1:0] prod;
    prod = bump_inc * decay_recip;
    prod = prod >> 16;
    bump_inc = (|prod[ACC_W-1:ACT_W]) ? '1 : prod[ACT_W-1:0];
    if (bump_inc == '0) bump_inc = ACT_W'(1);
  endfunction

  function automatic pick_result_t best_free();
    pick_result_t     r;
    logic [ACT_W-1:0] top_act;
    int unsigned      best;
    int unsigned      n;
    int unsigned      i;
    bit               have;
    n = live_count();
    best = 0;
    top_act = '0;
    have = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!marks[i] && (!have || activity[i] > top_act)) begin
        have = 1'b1;
        best = i;
        top_act = activity[i];
      end
    end
    r.picked_var = have ? best[VAR_W-1:0] : '0;
    r.found = have;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pick_result_t want;
    int unsigned  i;
    if (!rst_ni) begin
      for (i = 0; i < NUM_VARS; i++) begin
        activity[i] = '0;
        marks[i] = 1'b0;
      end
      bump_inc = INC_RESET;
      active_vars = AV_RESET;
      decay_recip = RECIP_RESET;
      expected_picks.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_ACTIVE_VARS, 2'b00}) active_vars = pwdata[AV_W-1:0];
        else if (paddr == {REG_DECAY_RECIP, 2'b00}) decay_recip = pwdata[RECIP_W-1:0];
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_picks.size() == 0) begin
          $error("result with no pick outstanding: picked_var %0d found %0d",
                 rsp_i.picked_var, rsp_i.found);
          mismatches++;
        end else begin
          want = expected_picks.pop_front();
          if (rsp_i.picked_var !== want.picked_var) begin
            $error("picked_var expected %0d actual %0d", want.picked_var, rsp_i.picked_var);
            mismatches++;
          end
          if (rsp_i.found !== want.found) begin
            $error("found expected %0d actual %0d", want.found, rsp_i.found);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        case (req_i.func)
          FUNC_BUMP:  apply_bump(req_i.var_index);
          FUNC_DECAY: apply_decay();
          FUNC_PICK:  expected_picks.push_back(best_free());
          FUNC_MARK: begin
            if (req_i.var_index < NUM_VARS) marks[req_i.var_index] = req_i.assigned_flag;
          end
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o <= expected_picks.size();
    end
  end

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
module testbench;
  import vap_pkg::*;

  // no request or result moves for this long: the block is hung
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // longest request without a result (decay) plus margin
  localparam int unsigned SETTLE_CYCLES  = 12;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           fail_count;
  int unsigned           picks_pending;
  int unsigned           stall_left = 0;
  int unsigned           quiet_cycles = 0;
  // no idling on either side while set
  bit                    steady = 1'b0;

  vap_req_if req ();
  vap_rsp_if rsp ();

  vsids_activity_picker_unit #(
    .NUM_VARS(256)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  vap_pick_predictor #(
    .NUM_VARS(256)
  ) predictor_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_i       (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (picks_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Result side: hold ready low for random stretches unless steady.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (steady) begin
      rsp.ready <= 1'b1;
    end else if (stall_left != 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
      if ($urandom_range(99) < 20) stall_left <= gap_length();
    end
  end

  // Watchdog: count cycles in which nothing moves on any port.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("vsids_activity_picker_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until taken; valid stays high when
  // the next request follows back to back.
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [VAR_W-1:0] v,
                          input logic flag);
    int unsigned gap;
    req.valid <= 1'b1;
    req.func <= f;
    req.var_index <= v;
    req.assigned_flag <= flag;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    gap = steady ? 0 : gap_length();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every pick result, then let a trailing bump or
  // decay finish inside the block.
  task automatic drain_and_settle();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (picks_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup then access; psel stays high into the next write's setup.
  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic configure(input logic [AV_W-1:0] av, input logic [RECIP_W-1:0] dr);
    drain_and_settle();
    write_reg({REG_ACTIVE_VARS, 2'b00}, APB_DATA_W'(av));
    write_reg({REG_DECAY_RECIP, 2'b00}, APB_DATA_W'(dr));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One setting, then random requests. Four in ten land on a few hot
  // variables so activities climb toward the rescale threshold; a tenth
  // go anywhere, which often means out of range.
  task automatic run_phase(input logic [AV_W-1:0] av, input logic [RECIP_W-1:0] dr,
                           input int unsigned count, input int unsigned decay_pct,
                           input bit no_idle, input bit pause_midway);
    logic [FUNC_W-1:0] f;
    logic [VAR_W-1:0]  v;
    int unsigned       live;
    int unsigned       hot;
    int unsigned       r;
    int unsigned       k;
    configure(av, dr);
    steady <= no_idle;
    live = (av > 256) ? 256 : av;
    hot = (live < 8) ? live : 8;
    for (k = 0; k < count; k++) begin
      // sender holds off until the block has answered every pick
      if (pause_midway && k == count / 2) drain_and_settle();
      r = $urandom_range(99);
      if (r < decay_pct) f = FUNC_DECAY;
      else if (r < decay_pct + 15) f = FUNC_PICK;
      else if (r < decay_pct + 30) f = FUNC_MARK;
      else f = FUNC_BUMP;
      r = $urandom_range(9);
      if (live == 0 || r == 0) v = VAR_W'($urandom_range(255));
      else if (r < 5) v = VAR_W'($urandom_range(hot - 1));
      else v = VAR_W'($urandom_range(live - 1));
      send_req(f, v, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    req.valid <= 1'b0;
    req.func <= FUNC_BUMP;
    req.var_index <= '0;
    req.assigned_flag <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: all-zero tie goes to the lowest index, then steer
    // the winner with bumps, marks and a decay.
    send_req(FUNC_PICK, 8'd0, 1'b0);
    send_req(FUNC_BUMP, 8'd255, 1'b0);
    send_req(FUNC_PICK, 8'd0, 1'b0);
    send_req(FUNC_MARK, 8'd255, 1'b1);
    send_req(FUNC_PICK, 8'd0, 1'b0);
    send_req(FUNC_BUMP, 8'd0, 1'b0);
    send_req(FUNC_BUMP, 8'd0, 1'b0);
    send_req(FUNC_DECAY, 8'd0, 1'b0);
    send_req(FUNC_BUMP, 8'd128, 1'b0);
    send_req(FUNC_PICK, 8'd0, 1'b0);
    send_req(FUNC_MARK, 8'd0, 1'b1);
    send_req(FUNC_PICK, 8'd0, 1'b0);
    send_req(FUNC_MARK, 8'd255, 1'b0);
    send_req(FUNC_PICK, 8'd0, 1'b0);

    // No variables in use: picks find nothing, bumps are dropped, marks
    // still land.
    configure(9'd0, 18'd131072);
    send_req(FUNC_PICK, 8'd0, 1'b0);
    send_req(FUNC_BUMP, 8'd0, 1'b0);
    send_req(FUNC_MARK, 8'd7, 1'b1);
    send_req(FUNC_PICK, 8'd0, 1'b0);

    // Two variables, both assigned, then one freed; unity decay.
    configure(9'd2, 18'd65536);
    send_req(FUNC_MARK, 8'd1, 1'b1);
    send_req(FUNC_PICK, 8'd0, 1'b0);
    send_req(FUNC_DECAY, 8'd0, 1'b0);
    send_req(FUNC_MARK, 8'd1, 1'b0);
    send_req(FUNC_PICK, 8'd0, 1'b0);

    // Random phases: reset-like, fast growth into rescales, saturating
    // growth with no idling, a single variable, a count above the table,
    // a shrinking and a zero reciprocal, then growth again.
    run_phase(9'd256, 18'd68985, 140, 10, 1'b0, 1'b0);
    run_phase(9'd16, 18'd131072, 150, 35, 1'b0, 1'b1);
    run_phase(9'd511, 18'd262143, 100, 30, 1'b1, 1'b0);
    run_phase(9'd1, 18'd65536, 60, 10, 1'b0, 1'b0);
    run_phase(9'd300, 18'd32768, 80, 20, 1'b0, 1'b0);
    run_phase(9'd256, 18'd0, 40, 20, 1'b0, 1'b0);
    run_phase(9'd200, 18'd131072, 80, 35, 1'b0, 1'b0);

    drain_and_settle();
    if (fail_count == 0 && picks_pending == 0) begin
      $display("vsids_activity_picker_unit verification clean");
    end else begin
      $display("vsids_activity_picker_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
